// ----- hdl/ultrasonic_echo_ranger_assert.svh -----
// Assertion macros shared by the ranger modules.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a condition in the same cycle as its cause.
`define UER_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ranger assertion failed");
// Check a condition in the cycle after its cause.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ranger assertion failed");
`else
`define UER_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/uer_pkg.sv -----
package uer_pkg;

    localparam int TS_W    = 32;
    localparam int DIST_W  = 10;
    localparam int SPEED_W = 31;
    localparam int PROD_W  = 60;
    localparam int NUM_W   = 30;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int DIST_SHIFT = 33;

    localparam logic [27:0]       DIST_SCALE   = 28'd147733565;
    localparam logic [DIST_W-1:0] DIST_MAX     = 10'd999;
    localparam logic [19:0]       USEC_PER_SEC = 20'd1000000;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_EDGE = 2'd1;
    localparam logic [1:0] CMD_POLL = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    localparam logic [2:0] RS_START     = 3'd0;
    localparam logic [2:0] RS_UP        = 3'd1;
    localparam logic [2:0] RS_READY     = 3'd2;
    localparam logic [2:0] RS_LISTENING = 3'd3;
    localparam logic [2:0] RS_DETECTED  = 3'd4;
    localparam logic [2:0] RS_QUIESCENT = 3'd5;

    localparam logic [1:0] REP_NONE  = 2'd0;
    localparam logic [1:0] REP_NODET = 2'd1;
    localparam logic [1:0] REP_DIST  = 2'd2;
    localparam logic [1:0] REP_SPEED = 2'd3;

    typedef struct packed {
        logic latch;
        logic event_op;
        logic dist_op;
        logic div_step;
        logic fix;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic measure;
        logic need_div;
        logic out_free;
    } t_dp_status;

endpackage

// ----- hdl/uer_ctrl.sv -----
`include "ultrasonic_echo_ranger_assert.svh"

module uer_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  uer_pkg::t_dp_status   i_sts,
    output uer_pkg::t_dp_cmd      o_cmd
);

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_EVENT = 3'd1;
    localparam logic [2:0] C_DIST  = 3'd2;
    localparam logic [2:0] C_DIV   = 3'd3;
    localparam logic [2:0] C_FIX   = 3'd4;
    localparam logic [2:0] C_DONE  = 3'd5;

    logic [2:0]                r_state, n_state;
    logic [uer_pkg::CNT_W-1:0] r_cnt, n_cnt;

    assign s_axis_tready = (r_state == C_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            C_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = C_EVENT;
                end
            end
            C_EVENT: begin
                o_cmd.event_op = 1'b1;
                n_state = i_sts.measure ? C_DIST : C_DONE;
            end
            C_DIST: begin
                o_cmd.dist_op = 1'b1;
                if (i_sts.need_div) begin
                    n_state = C_DIV;
                    n_cnt   = uer_pkg::CNT_W'(uer_pkg::NUM_W);
                end else begin
                    n_state = C_DONE;
                end
            end
            C_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == uer_pkg::CNT_W'(1)) begin
                    n_state = C_FIX;
                end
            end
            C_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = C_DONE;
            end
            C_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `UER_ASSERT_NEXT(a_accept_event, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state == C_EVENT)
    `UER_ASSERT_NEXT(a_done_hold, i_clk, i_rst_n, (r_state == C_DONE) && !i_sts.out_free, r_state == C_DONE)
    `UER_ASSERT_SAME(a_div_count, i_clk, i_rst_n, r_state == C_DIV, r_cnt != '0)

endmodule

// ----- hdl/uer_dp.sv -----
`include "ultrasonic_echo_ranger_assert.svh"

module uer_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    input  logic [1:0]                    i_in_cmd,
    input  logic                          i_in_level,
    input  logic [uer_pkg::TS_W-1:0]      i_in_ts,
    input  logic                          i_in_req,
    input  logic                          i_out_ready,
    input  uer_pkg::t_dp_cmd              i_cmd,
    output uer_pkg::t_dp_status           o_sts,
    output logic                          o_out_valid,
    output logic                          o_out_trig,
    output logic [1:0]                    o_out_report,
    output logic [uer_pkg::DIST_W-1:0]    o_out_dist,
    output logic [uer_pkg::SPEED_W-1:0]   o_out_speed
);

    localparam int TS_W   = uer_pkg::TS_W;
    localparam int DIST_W = uer_pkg::DIST_W;
    localparam int NUM_W  = uer_pkg::NUM_W;
    localparam int SPD_W  = uer_pkg::SPEED_W;
    localparam int PROD_W = uer_pkg::PROD_W;
    localparam int SH     = uer_pkg::DIST_SHIFT;

    logic              r_single;
    logic [2:0]        r_rstate;
    logic              r_echo_seen;
    logic [TS_W-1:0]   r_start, r_end, r_prev_t;
    logic [DIST_W-1:0] r_prev_d;
    logic              r_pend, r_first;

    logic [1:0]        r_cmd;
    logic              r_lvl, r_req;
    logic [TS_W-1:0]   r_ts;

    logic [PROD_W-1:0] r_prod;

    logic              r_trig;
    logic [1:0]        r_rep;
    logic [DIST_W-1:0] r_dist;
    logic [SPD_W-1:0]  r_speed;

    logic [NUM_W-1:0]  r_num;
    logic [TS_W-1:0]   r_rem, r_den;
    logic              r_neg;

    logic              r_ov, r_o_trig;
    logic [1:0]        r_o_rep;
    logic [DIST_W-1:0] r_o_dist;
    logic [SPD_W-1:0]  r_o_speed;

    logic [TS_W-1:0]       w_width;
    logic [PROD_W-1:0]     w_prod;
    logic                  w_over;
    logic [DIST_W-1:0]     w_dist;
    logic signed [DIST_W:0] w_dd;
    logic [DIST_W-1:0]     w_dd_mag;
    logic [NUM_W-1:0]      w_num;
    logic [TS_W-1:0]       w_td, w_td_mag;
    logic [TS_W:0]         w_rem_sh, w_diff;
    logic [SPD_W-1:0]      w_q;

    assign w_width = r_end - r_start;
    assign w_prod  = PROD_W'(w_width) * PROD_W'(uer_pkg::DIST_SCALE);
    assign w_over  = (r_prod[PROD_W-1:SH] > (PROD_W - SH)'(uer_pkg::DIST_MAX));
    assign w_dist  = r_prod[SH+DIST_W-1:SH];

    assign w_dd     = $signed({1'b0, w_dist}) - $signed({1'b0, r_prev_d});
    assign w_dd_mag = w_dd[DIST_W] ? DIST_W'(-w_dd) : w_dd[DIST_W-1:0];
    assign w_num    = NUM_W'(w_dd_mag) * NUM_W'(uer_pkg::USEC_PER_SEC);
    assign w_td     = r_ts - r_prev_t;
    assign w_td_mag = w_td[TS_W-1] ? (~w_td + 1'b1) : w_td;

    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_q      = SPD_W'(r_num);

    assign o_sts.measure  = (r_cmd == uer_pkg::CMD_POLL) &&
                            (r_rstate == uer_pkg::RS_QUIESCENT) && r_echo_seen;
    assign o_sts.need_div = !w_over && !r_single && !r_first &&
                            (r_prev_t != '0) && (r_ts != r_prev_t);
    assign o_sts.out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.latch) begin
            r_cmd <= i_in_cmd;
            r_lvl <= i_in_level;
            r_ts  <= i_in_ts;
            r_req <= i_in_req;
        end
        if (i_cmd.event_op) begin
            r_trig  <= 1'b0;
            r_rep   <= uer_pkg::REP_NONE;
            r_dist  <= '0;
            r_speed <= '0;
            if (r_cmd == uer_pkg::CMD_POLL) begin
                r_trig <= r_pend || r_req;
                if (r_rstate == uer_pkg::RS_QUIESCENT && !r_echo_seen) begin
                    r_rep <= uer_pkg::REP_NODET;
                end
            end
        end
        if (i_cmd.dist_op) begin
            if (w_over) begin
                r_rep <= uer_pkg::REP_NODET;
            end else begin
                r_dist <= w_dist;
                if (r_single || r_first) begin
                    r_rep <= uer_pkg::REP_DIST;
                end else begin
                    r_rep <= uer_pkg::REP_SPEED;
                end
            end
            r_num <= w_num;
            r_den <= w_td_mag;
            r_rem <= '0;
            r_neg <= w_dd[DIST_W] ^ w_td[TS_W-1];
        end
        if (i_cmd.div_step) begin
            if (!w_diff[TS_W]) begin
                r_rem <= w_diff[TS_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[TS_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.fix) begin
            r_speed <= r_neg ? (~w_q + 1'b1) : w_q;
        end
        if (i_cmd.load_out) begin
            r_o_trig  <= r_trig;
            r_o_rep   <= r_rep;
            r_o_dist  <= r_dist;
            r_o_speed <= r_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single    <= 1'b0;
            r_rstate    <= uer_pkg::RS_START;
            r_echo_seen <= 1'b0;
            r_start     <= '0;
            r_end       <= '0;
            r_pend      <= 1'b0;
            r_prev_t    <= '0;
            r_prev_d    <= '0;
            r_first     <= 1'b1;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_single <= i_cfg_wr_data;
            end
            if (i_cmd.event_op) begin
                case (r_cmd)
                    uer_pkg::CMD_TICK: begin
                        case (r_rstate) inside
                            uer_pkg::RS_START, uer_pkg::RS_UP,
                            uer_pkg::RS_QUIESCENT: begin
                                r_rstate <= uer_pkg::RS_READY;
                            end
                            uer_pkg::RS_LISTENING: begin
                                r_echo_seen <= 1'b0;
                                r_rstate    <= uer_pkg::RS_QUIESCENT;
                            end
                            uer_pkg::RS_DETECTED: begin
                                r_echo_seen <= 1'b1;
                                r_rstate    <= uer_pkg::RS_QUIESCENT;
                            end
                            default: begin
                            end
                        endcase
                    end
                    uer_pkg::CMD_EDGE: begin
                        if (r_lvl) begin
                            r_start  <= r_ts;
                            r_rstate <= uer_pkg::RS_LISTENING;
                        end else begin
                            r_end    <= r_ts;
                            r_rstate <= uer_pkg::RS_DETECTED;
                        end
                    end
                    uer_pkg::CMD_POLL: begin
                        r_pend <= (r_rstate == uer_pkg::RS_READY) && !r_single;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.dist_op) begin
                if (r_single) begin
                    r_rstate <= uer_pkg::RS_READY;
                end else if (!w_over) begin
                    r_first  <= 1'b0;
                    r_prev_t <= r_ts;
                    r_prev_d <= w_dist;
                end
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_trig   = r_o_trig;
    assign o_out_report = r_o_rep;
    assign o_out_dist   = r_o_dist;
    assign o_out_speed  = r_o_speed;

    `UER_ASSERT_SAME(a_speed_only_rep3, i_clk, i_rst_n, r_ov && (r_o_rep != uer_pkg::REP_SPEED), r_o_speed == '0)
    `UER_ASSERT_SAME(a_dist_range, i_clk, i_rst_n, r_ov, r_o_dist <= uer_pkg::DIST_MAX)
    `UER_ASSERT_SAME(a_no_dist_nodet, i_clk, i_rst_n, r_ov && ((r_o_rep == uer_pkg::REP_NONE) || (r_o_rep == uer_pkg::REP_NODET)), r_o_dist == '0)

endmodule

// ----- hdl/ultrasonic_echo_ranger.sv -----
// Channel   Direction  tdata (low bit up)                       tuser
// s_axis    in         echo_level, timestamp[32], pulse_request  cmd[2]
// m_axis    out        trigger, distance_cm[10], speed_cm_s[31]  report[2]
// cfg       in         single_pulse_mode (i_cfg_wr_en/i_cfg_wr_data)
//
// Ticks, edges and polls with no echo to measure: event step, then result load.
// A poll that measures an echo adds a distance step; one that computes a speed
// also runs the one-bit-per-cycle 30-step restoring divider and a sign fix.
// Reset is synchronous, active low; no clearing pass.
// A finished result waits in the output register while m_axis_tready is low;
// the next item is taken once the previous result is in that register.
module ultrasonic_echo_ranger (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // echo_level, timestamp, pulse_request, zero fill
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // trigger, distance_cm, speed_cm_s, zero fill
    output logic [1:0]  m_axis_tuser   // report
);

    uer_pkg::t_dp_cmd    w_cmd;
    uer_pkg::t_dp_status w_sts;

    logic                          w_trig;
    logic [uer_pkg::DIST_W-1:0]    w_dist;
    logic [uer_pkg::SPEED_W-1:0]   w_speed;

    uer_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    uer_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_cmd      (s_axis_tuser),
        .i_in_level    (s_axis_tdata[0]),
        .i_in_ts       (s_axis_tdata[32:1]),
        .i_in_req      (s_axis_tdata[33]),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .o_out_trig    (w_trig),
        .o_out_report  (m_axis_tuser),
        .o_out_dist    (w_dist),
        .o_out_speed   (w_speed)
    );

    assign m_axis_tdata = {6'b0, w_speed, w_dist, w_trig};

endmodule
